// ===== rtl/dmrms_pkg.sv =====
package dmrms_pkg;

  localparam int unsigned MaxChannels    = 8;
  localparam int unsigned MaxBlockFrames = 4096;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ChanW   = 4;
  // channel sum of up to eight samples
  localparam int unsigned SumW    = SampleW + $clog2(MaxChannels);
  // frame counter holds 0 .. MaxBlockFrames
  localparam int unsigned FcntW   = $clog2(MaxBlockFrames) + 1;
  localparam int unsigned SqW     = 2 * SampleW - 1;
  // sum of squares, 43 bits
  localparam int unsigned AccW    = SqW + FcntW - 1;
  // input queue between front and back
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);

  typedef struct packed {
    logic signed [SampleW-1:0] sample_0;
    logic signed [SampleW-1:0] sample_1;
    logic signed [SampleW-1:0] sample_2;
    logic signed [SampleW-1:0] sample_3;
    logic signed [SampleW-1:0] sample_4;
    logic signed [SampleW-1:0] sample_5;
    logic signed [SampleW-1:0] sample_6;
    logic signed [SampleW-1:0] sample_7;
    logic                      block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] mono_sample;
    logic                      level_valid;
    logic        [SampleW-1:0] level;
  } out_item_t;

  // classified frame as handed from front to back
  typedef struct packed {
    logic signed [SumW-1:0] chan_sum;
    logic [ChanW-1:0]       chans;
    logic                   block_end;
  } job_t;

endpackage

// ===== rtl/dmrms_front.sv =====
module dmrms_front import dmrms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ChanW-1:0] cfg_wdata_i,
  input  logic             in_push_i,
  input  in_item_t         in_item_i,
  output logic             in_full_o,
  input  logic             q_full_i,
  output logic             q_push_o,
  output job_t             q_job_o
);

  logic [ChanW-1:0]          chan_cfg_q;
  logic [ChanW-1:0]          chans;
  logic signed [SampleW-1:0] smp [MaxChannels];
  logic signed [SumW-1:0]    sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg_q <= ChanW'(1);
    end else if (cfg_we_i) begin
      chan_cfg_q <= cfg_wdata_i;
    end
  end

  // zero counts as one channel, anything above eight as eight
  always_comb begin
    if (chan_cfg_q == '0) begin
      chans = ChanW'(1);
    end else if (chan_cfg_q > ChanW'(MaxChannels)) begin
      chans = ChanW'(MaxChannels);
    end else begin
      chans = chan_cfg_q;
    end
  end

  assign smp[0] = in_item_i.sample_0;
  assign smp[1] = in_item_i.sample_1;
  assign smp[2] = in_item_i.sample_2;
  assign smp[3] = in_item_i.sample_3;
  assign smp[4] = in_item_i.sample_4;
  assign smp[5] = in_item_i.sample_5;
  assign smp[6] = in_item_i.sample_6;
  assign smp[7] = in_item_i.sample_7;

  always_comb begin
    sum = '0;
    for (int c = 0; c < MaxChannels; c++) begin
      if (ChanW'(c) < chans) begin
        sum = sum + SumW'(smp[c]);
      end
    end
  end

  assign in_full_o          = q_full_i;
  assign q_push_o           = in_push_i && !q_full_i;
  assign q_job_o.chan_sum   = sum;
  assign q_job_o.chans      = chans;
  assign q_job_o.block_end  = in_item_i.block_end;

endmodule

// ===== rtl/dmrms_fifo.sv =====
module dmrms_fifo import dmrms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_job_o,
  output logic empty_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign full_o    = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPtrW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/dmrms_back.sv =====
module dmrms_back import dmrms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  job_t      q_job_i,
  output logic      q_pop_o,
  output logic      out_empty_o,
  input  logic      out_pop_i,
  output out_item_t out_item_o
);

  localparam int unsigned StW   = 3;
  localparam logic [StW-1:0] S_IDLE = 3'd0;
  localparam logic [StW-1:0] S_MDIV = 3'd1;
  localparam logic [StW-1:0] S_SQ   = 3'd2;
  localparam logic [StW-1:0] S_ACC  = 3'd3;
  localparam logic [StW-1:0] S_LDIV = 3'd4;
  localparam logic [StW-1:0] S_SQRT = 3'd5;
  localparam logic [StW-1:0] S_OUT  = 3'd6;

  localparam int unsigned CntW  = $clog2(AccW + 1);
  localparam int unsigned DvW   = FcntW;
  localparam int unsigned MeanW = SqW;
  localparam int unsigned ResW  = MeanW + 1;
  localparam int unsigned SqSteps = (MeanW + 1) / 2;

  logic [StW-1:0]  state_q, state_d;

  // shared restoring divider, one quotient bit a cycle
  logic [AccW-1:0] dq_q, dq_d;
  logic [DvW-1:0]  rem_q, rem_d;
  logic [DvW-1:0]  dv_q, dv_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvW:0]    rem_sh;
  logic            ge;

  // square root by digit pairs
  logic [MeanW-1:0] sx_q, sx_d;
  logic [ResW-1:0]  sres_q, sres_d;
  logic [MeanW-1:0] sbit_q, sbit_d;
  logic [ResW-1:0]  strial;

  logic [AccW-1:0]  acc_q, acc_d;
  logic [FcntW-1:0] fcnt_q, fcnt_d;

  logic                      neg_q, neg_d;
  logic                      blk_q, blk_d;
  logic [SampleW-1:0]        mag_q, mag_d;
  logic [SqW-1:0]            sq_q, sq_d;
  logic [SumW-1:0]           abs_sum;
  logic [SampleW-1:0]        level;

  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  assign out_free    = !out_valid_q || out_pop_i;
  assign out_empty_o = !out_valid_q;
  assign out_item_o  = out_q;

  assign abs_sum = q_job_i.chan_sum[SumW-1] ? SumW'(-q_job_i.chan_sum)
                                            : SumW'(q_job_i.chan_sum);
  assign rem_sh  = {rem_q, dq_q[AccW-1]};
  assign ge      = rem_sh >= {1'b0, dv_q};
  assign strial  = sres_q + ResW'(sbit_q);
  assign level   = SampleW'(sres_q);

  always_comb begin
    state_d     = state_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    cnt_d       = cnt_q;
    sx_d        = sx_q;
    sres_d      = sres_q;
    sbit_d      = sbit_q;
    acc_d       = acc_q;
    fcnt_d      = fcnt_q;
    neg_d       = neg_q;
    blk_d       = blk_q;
    mag_d       = mag_q;
    sq_d        = sq_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_pop_i;
    q_pop_o     = 1'b0;

    if (state_q == S_MDIV || state_q == S_LDIV) begin
      rem_d = ge ? DvW'(rem_sh - {1'b0, dv_q}) : DvW'(rem_sh);
      dq_d  = {dq_q[AccW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          neg_d   = q_job_i.chan_sum[SumW-1];
          blk_d   = q_job_i.block_end;
          // magnitude sits at the top so only SumW steps are needed
          dq_d    = {abs_sum, (AccW-SumW)'(0)};
          rem_d   = '0;
          dv_d    = DvW'(q_job_i.chans);
          cnt_d   = CntW'(SumW);
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        if (cnt_q == CntW'(1)) begin
          mag_d   = SampleW'({dq_q[SumW-2:0], ge});
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        sq_d    = SqW'(mag_q * mag_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (fcnt_q < FcntW'(MaxBlockFrames)) begin
          acc_d  = acc_q + AccW'(sq_q);
          fcnt_d = fcnt_q + FcntW'(1);
        end
        if (blk_q) begin
          dq_d    = acc_d;
          rem_d   = '0;
          dv_d    = fcnt_d;
          cnt_d   = CntW'(AccW);
          acc_d   = '0;
          fcnt_d  = '0;
          state_d = S_LDIV;
        end else begin
          sres_d  = '0;
          state_d = S_OUT;
        end
      end
      S_LDIV: begin
        if (cnt_q == CntW'(1)) begin
          sx_d    = MeanW'({dq_q[AccW-2:0], ge});
          sres_d  = '0;
          sbit_d  = MeanW'(1) << (MeanW - 1);
          cnt_d   = CntW'(SqSteps);
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (ResW'(sx_q) >= strial) begin
          sx_d   = MeanW'(ResW'(sx_q) - strial);
          sres_d = (sres_q >> 1) + ResW'(sbit_q);
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_d.mono_sample = neg_q ? -mag_q : mag_q;
          out_d.level_valid = blk_q;
          out_d.level       = blk_q ? level : '0;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      fcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      fcnt_q      <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    cnt_q  <= cnt_d;
    sx_q   <= sx_d;
    sres_q <= sres_d;
    sbit_q <= sbit_d;
    neg_q  <= neg_d;
    blk_q  <= blk_d;
    mag_q  <= mag_d;
    sq_q   <= sq_d;
    out_q  <= out_d;
  end

endmodule

// ===== rtl/downmix_rms_level_meter_top.sv =====
// Downmixing RMS level meter.
// Input side is a queue: present a frame item on in_item_i with push; it is
// taken at a clock edge where push is high and full is low. The front sums the
// first channel_count samples and files the frame into a four-deep queue.
// Result side is a queue too: while empty is low the oldest result item sits on
// out_item_o, and it leaves at an edge where pop is high and empty is low.
// Every frame yields one item: the channel average (toward zero) as mono_sample;
// on a block_end frame also level_valid and the block RMS level.
// The back end's shared one-bit-a-cycle divider does the channel division and,
// on a block_end frame, the 43-step mean division before a 16-step square root.
// The back end works on one frame at a time: it takes the next frame from the
// queue only once the last one's item has gone into the output register.
// Channel count is written through cfg_we_i / cfg_wdata_i while idle; the user
// must keep to this, as the block itself does not enforce it.
// Reset: channel count 1, accumulator and frame count cleared, both queues empty.
// If the receiver stalls the finished item holds in the output register, the
// back end waits, and the input queue keeps taking frames until it fills.
module downmix_rms_level_meter_top import dmrms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ChanW-1:0] cfg_wdata_i,
  input  logic             push,
  input  in_item_t         in_item_i,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item_o
);

  // front to queue
  logic q_push, q_full;
  job_t q_in_job;
  // queue to back
  logic q_pop, q_empty;
  job_t q_out_job;

  dmrms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_push_i   (push),
    .in_item_i   (in_item_i),
    .in_full_o   (full),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_in_job)
  );

  dmrms_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_in_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (q_out_job),
    .empty_o    (q_empty)
  );

  dmrms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_out_job),
    .q_pop_o     (q_pop),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/tb_downmix_rms_level_meter_top.sv =====
`timescale 1ns / 100ps

import dmrms_pkg::*;

// Expected-result store plus a behavioural copy of the meter state.
class level_meter_scoreboard;
  logic [ChanW-1:0] chan_setting;
  logic [FcntW-1:0] frames_in_block;
  logic [AccW-1:0]  square_sum;
  out_item_t        expected_q[$];
  int unsigned      errors;
  int unsigned      results_seen;

  function new();
    chan_setting    = ChanW'(1);
    frames_in_block = '0;
    square_sum      = '0;
    errors          = 0;
    results_seen    = 0;
  endfunction

  function void set_channels(input logic [ChanW-1:0] v);
    chan_setting = v;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // root built bit by bit from the top; the mean is below 2^42
  function logic [SampleW-1:0] floor_root(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[SampleW-1:0];
  endfunction

  // downmix one frame, fold it into the block, queue the item it gives
  function void note_frame(input in_item_t f);
    logic [SampleW*MaxChannels:0] raw;
    int                           n;
    int                           acc;
    int                           mono;
    longint unsigned              mag;
    out_item_t                    exp_item;
    raw = f;
    n = int'(chan_setting);
    if (n < 1) n = 1;
    if (n > int'(MaxChannels)) n = int'(MaxChannels);
    acc = 0;
    for (int c = 0; c < n; c++) begin
      acc += int'($signed(raw[SampleW*(MaxChannels-c) -: SampleW]));
    end
    mono = acc / n;
    mag = 64'((mono < 0) ? -mono : mono);
    if (frames_in_block < MaxBlockFrames) begin
      square_sum = square_sum + AccW'(mag * mag);
      frames_in_block++;
    end
    exp_item.mono_sample = 16'(mono);
    exp_item.level_valid = f.block_end;
    exp_item.level       = '0;
    if (f.block_end) begin
      exp_item.level  = floor_root((frames_in_block != 0)
                                   ? 64'(square_sum / AccW'(frames_in_block)) : 64'd0);
      frames_in_block = '0;
      square_sum      = '0;
    end
    expected_q.push_back(exp_item);
  endfunction

  task report(input string what);
    errors++;
    $display("%0t level meter mismatch: %s", $time, what);
  endtask

  task check_item(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d: item with nothing expected", results_seen));
      return;
    end
    want = expected_q.pop_front();
    if (got.mono_sample !== want.mono_sample)
      report($sformatf("result %0d: mono_sample %0d, want %0d",
                       results_seen, got.mono_sample, want.mono_sample));
    if (got.level_valid !== want.level_valid)
      report($sformatf("result %0d: level_valid %b, want %b",
                       results_seen, got.level_valid, want.level_valid));
    if (got.level !== want.level)
      report($sformatf("result %0d: level %0d, want %0d",
                       results_seen, got.level, want.level));
  endtask
endclass

module tb_downmix_rms_level_meter_top;

  // cycles with no item moving either way before the run is called hung;
  // the slowest honest gap is a block-end item's pass through the back end
  // behind a long receiver stall, so this is many times over
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned SegItems    = 100;
  localparam int unsigned NumSegments = 14;

  // channel setting per random segment: zero, saturating values and both ends
  localparam logic [ChanW-1:0] SegChans [NumSegments] =
    '{4'd15, 4'd2, 4'd5, 4'd0, 4'd8, 4'd4, 4'd1,
      4'd6, 4'd3, 4'd9, 4'd7, 4'd12, 4'd1, 4'd8};

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ChanW-1:0] cfg_wdata_i;
  logic             push;
  in_item_t         in_item;
  logic             full;
  logic             empty;
  logic             pop;
  out_item_t        out_item;

  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 25;
  int unsigned quiet_cycles  = 0;

  level_meter_scoreboard meter_sb = new();

  downmix_rms_level_meter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .in_item_i   (in_item),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --- stimulus helpers ---------------------------------------------------

  // sample mix: full-scale ends and values near zero turn up often
  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'(int'($urandom_range(31)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_frame(input logic be);
    in_item_t f;
    f.sample_0  = rand_sample();
    f.sample_1  = rand_sample();
    f.sample_2  = rand_sample();
    f.sample_3  = rand_sample();
    f.sample_4  = rand_sample();
    f.sample_5  = rand_sample();
    f.sample_6  = rand_sample();
    f.sample_7  = rand_sample();
    f.block_end = be;
    return f;
  endfunction

  function automatic in_item_t uniform_frame(input logic signed [SampleW-1:0] v,
                                             input logic be);
    return {v, v, v, v, v, v, v, v, be};
  endfunction

  // Offer one frame, with a random gap first. push is left high once the
  // item is taken, so back-to-back items need no drop; whoever comes next
  // lowers it in the same step if it has nothing to send.
  task automatic send_frame(input in_item_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= f;
    do @(posedge clk_i); while (full);
    meter_sb.note_frame(f);
  endtask

  // Register write only with the block idle: every item gives a result, so
  // once nothing is outstanding the back end has nothing in flight.
  task automatic write_channels(input logic [ChanW-1:0] v);
    push <= 1'b0;
    while (meter_sb.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    meter_sb.set_channels(v);
  endtask

  // --- result side --------------------------------------------------------

  // Handshake values are read just after the edge, before the block's own
  // updates land, i.e. as the block saw them at that edge.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) meter_sb.check_item(out_item);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: any item either way, or a register write, counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_downmix_rms_level_meter_top: errors");
        $finish;
      end
    end
  end

  // --- main sequence ------------------------------------------------------

  initial begin
    in_item_t f;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    push        <= 1'b0;
    in_item     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting of one channel, full-scale both ways
    send_frame(uniform_frame(16'sh7fff, 1'b0));
    send_frame(uniform_frame(16'sh8000, 1'b1));

    // all eight channels, extremes and rounding toward zero both signs
    write_channels(4'd8);
    send_frame(uniform_frame(16'sh8000, 1'b0));
    send_frame(uniform_frame(16'sh7fff, 1'b0));
    f = uniform_frame(16'sd0, 1'b0);
    f.sample_0 = -16'sd15;
    send_frame(f);
    f.sample_0 = 16'sd15;
    f.block_end = 1'b1;
    send_frame(f);

    // zero channels acts as one; the rest of the frame must be ignored
    write_channels(4'd0);
    f = uniform_frame(16'sh7fff, 1'b1);
    f.sample_0 = -16'sd7;
    send_frame(f);

    // above eight saturates to eight
    write_channels(4'd15);
    send_frame(random_frame(1'b0));
    send_frame(uniform_frame(-16'sd1, 1'b1));

    // three channels, unused ones at full scale
    write_channels(4'd3);
    f = uniform_frame(16'sh7fff, 1'b0);
    f.sample_0 = 16'sd1;
    f.sample_1 = 16'sd2;
    f.sample_2 = 16'sd4;
    send_frame(f);
    f = uniform_frame(16'sh8000, 1'b1);
    f.sample_0 = -16'sd1;
    f.sample_1 = -16'sd2;
    f.sample_2 = -16'sd4;
    send_frame(f);

    // seven channels: silent block, then full scale
    write_channels(4'd7);
    f = uniform_frame(16'sd0, 1'b1);
    f.sample_7 = 16'sh7fff;
    send_frame(f);
    send_frame(uniform_frame(16'sh8000, 1'b0));
    send_frame(uniform_frame(16'sh7fff, 1'b1));

    // random: blocks of random length (about one end in eight) and content.
    // Sender mostly busy / receiver mostly stalled, then the reverse, then
    // flat out.
    for (int seg = 0; seg < NumSegments; seg++) begin
      if (seg < 5) begin
        send_idle_pct = 19;
        recv_idle_pct = 86;
      end else if (seg < 10) begin
        send_idle_pct = 86;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_channels(SegChans[seg]);
      repeat (SegItems) send_frame(random_frame($urandom_range(7) == 0));
    end

    // drain, then leave room for a stray late item to show up
    push <= 1'b0;
    while (meter_sb.pending() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (meter_sb.errors == 0) begin
      $display("tb_downmix_rms_level_meter_top: clean");
    end else begin
      $display("tb_downmix_rms_level_meter_top: errors");
    end
    $finish;
  end

endmodule
